// ----- hw/rtl/mbe_pkg.sv -----
// Shared types, constants and control store for the escape-time core.
package mbe_pkg;

  // Fixed-point format of z and c: fraction bits
  localparam int unsigned FRACTION_BITS = 28;

  localparam int unsigned LIMIT_W     = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;

  // |z|^2 threshold: 4.0 at 2*FRACTION_BITS fraction bits
  localparam logic [127:0] ESC_LIMIT = 128'd1 << (2 * FRACTION_BITS + 2);

  localparam int unsigned PC_W = 4;

  // 32-bit half of a magnitude fed to the multiplier
  typedef enum logic [1:0] {H_XL, H_XH, H_YL, H_YH} half_e;

  // Product accumulator that takes the registered partial product
  typedef enum logic [1:0] {D_NONE, D_XX, D_YY, D_XY} acc_dst_e;

  // Left shift of the partial product before accumulation
  typedef enum logic [1:0] {SH_0, SH_32, SH_33, SH_64} acc_sh_e;

  // Step operation
  typedef enum logic [2:0] {
    OP_NOP,      // multiply / accumulate only
    OP_MAG,      // take magnitudes and product sign of x, y
    OP_CHECK,    // leave on escape or on reaching the limit
    OP_COMBINE,  // xx - yy, signed 2xy
    OP_UPDATE    // new x, y; count up; jump
  } op_e;

  typedef enum logic {S_IDLE, S_RUN} seq_state_e;

  // One control word
  typedef struct packed {
    op_e             op;
    half_e           mul_a;
    half_e           mul_b;
    logic            mul_en;
    acc_dst_e        acc_dst;
    logic            acc_load;
    acc_sh_e         acc_sh;
    logic [PC_W-1:0] jump;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic   start;
    logic   step;
    logic   out_load;
    uword_t uw;
  } dp_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic escaped;
    logic at_limit;
  } dp_stat_t;

  function automatic uword_t mk(input op_e op, input half_e a, input half_e b,
                                input logic men, input acc_dst_e dst,
                                input logic ld, input acc_sh_e sh,
                                input logic [PC_W-1:0] jmp);
    uword_t w;
    w.op       = op;
    w.mul_a    = a;
    w.mul_b    = b;
    w.mul_en   = men;
    w.acc_dst  = dst;
    w.acc_load = ld;
    w.acc_sh   = sh;
    w.jump     = jmp;
    return w;
  endfunction

  // Control store: one pass of z = z^2 + c. Steps 1 to 10 multiply two halves,
  // and steps 2 to 11 accumulate the product of the step before. Cross terms of the
  // squares are taken once and doubled through the shift.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = mk(OP_MAG,     H_XL, H_XL, 1'b0, D_NONE, 1'b0, SH_0,  4'd0);
      4'd1:    w = mk(OP_NOP,     H_XL, H_XL, 1'b1, D_NONE, 1'b0, SH_0,  4'd0);
      4'd2:    w = mk(OP_NOP,     H_XH, H_XH, 1'b1, D_XX,   1'b1, SH_0,  4'd0);
      4'd3:    w = mk(OP_NOP,     H_XL, H_XH, 1'b1, D_XX,   1'b0, SH_64, 4'd0);
      4'd4:    w = mk(OP_NOP,     H_YL, H_YL, 1'b1, D_XX,   1'b0, SH_33, 4'd0);
      4'd5:    w = mk(OP_NOP,     H_YH, H_YH, 1'b1, D_YY,   1'b1, SH_0,  4'd0);
      4'd6:    w = mk(OP_NOP,     H_YL, H_YH, 1'b1, D_YY,   1'b0, SH_64, 4'd0);
      4'd7:    w = mk(OP_NOP,     H_XL, H_YL, 1'b1, D_YY,   1'b0, SH_33, 4'd0);
      4'd8:    w = mk(OP_CHECK,   H_XL, H_YH, 1'b1, D_XY,   1'b1, SH_0,  4'd0);
      4'd9:    w = mk(OP_NOP,     H_XH, H_YL, 1'b1, D_XY,   1'b0, SH_32, 4'd0);
      4'd10:   w = mk(OP_NOP,     H_XH, H_YH, 1'b1, D_XY,   1'b0, SH_32, 4'd0);
      4'd11:   w = mk(OP_NOP,     H_XL, H_XL, 1'b0, D_XY,   1'b0, SH_64, 4'd0);
      4'd12:   w = mk(OP_COMBINE, H_XL, H_XL, 1'b0, D_NONE, 1'b0, SH_0,  4'd0);
      4'd13:   w = mk(OP_UPDATE,  H_XL, H_XL, 1'b0, D_NONE, 1'b0, SH_0,  4'd0);
      default: w = mk(OP_NOP,     H_XL, H_XL, 1'b0, D_NONE, 1'b0, SH_0,  4'd0);
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/mbe_sequencer.sv -----
// Step counter, control store lookup and handshake control.
module mbe_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mbe_pkg::dp_stat_t stat_i,
  output mbe_pkg::dp_ctrl_t ctrl_o
);
  import mbe_pkg::*;

  seq_state_e      state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            out_valid_q, out_valid_d;
  uword_t          uw;
  logic            leave, hold, go;

  assign uw = ucode(pc_q);

  // Finish when the check step sees escape or the limit
  assign leave = (uw.op == OP_CHECK) && (stat_i.escaped || stat_i.at_limit);
  // Result register still full: wait on the check step
  assign hold  = leave && out_valid_q && !out_ready_i;
  assign go    = (state_q == S_RUN) && !hold;

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state, step counter and outputs
  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        pc_d = '0;
        if (in_valid_i) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (go) begin
          if (leave) begin
            state_d     = S_IDLE;
            out_valid_d = 1'b1;
            pc_d        = '0;
          end else if (uw.op == OP_UPDATE) begin
            pc_d = uw.jump;
          end else begin
            pc_d = pc_q + PC_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign ctrl_o.start    = in_valid_i && (state_q == S_IDLE);
  assign ctrl_o.step     = go;
  assign ctrl_o.out_load = go && leave;
  assign ctrl_o.uw       = uw;

endmodule

// ----- hw/rtl/mbe_datapath.sv -----
// Shared 32x32 multiplier, 128-bit product accumulators, z update and escape test.
module mbe_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [mbe_pkg::LIMIT_W-1:0] cfg_data_i,
  input  logic signed [31:0]         c_real_i,
  input  logic signed [31:0]         c_imag_i,
  input  mbe_pkg::dp_ctrl_t          ctrl_i,
  output mbe_pkg::dp_stat_t          stat_o,
  output logic [mbe_pkg::LIMIT_W-1:0] iteration_count_o,
  output logic                       stayed_bounded_o
);
  import mbe_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] n_q;
  logic [LIMIT_W-1:0] count_q;
  logic               bounded_q;
  logic signed [31:0] cr_q, ci_q;
  logic signed [63:0] x_q, y_q, x_d, y_d;
  logic [63:0]        mx_q, my_q;
  logic               neg_xy_q;
  logic [31:0]        op_a, op_b;
  logic [63:0]        prod_q, prod_d;
  logic [127:0]       pxx_q, pyy_q, pxy_q;
  logic [127:0]       addend, acc_base, acc_sum;
  logic [127:0]       mag2, xy2;
  logic signed [127:0] re_sh, im_sh, re_sum, im_sum;
  uword_t             uw;

  assign uw = ctrl_i.uw;

  function automatic logic [31:0] pick(input half_e h, input logic [63:0] mx,
                                       input logic [63:0] my);
    logic [31:0] r;
    case (h)
      H_XL:    r = mx[31:0];
      H_XH:    r = mx[63:32];
      H_YL:    r = my[31:0];
      H_YH:    r = my[63:32];
      default: r = mx[31:0];
    endcase
    return r;
  endfunction

  function automatic logic [63:0] absval(input logic signed [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Clamp a 128-bit value to the signed 64-bit range
  function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
    logic signed [63:0] r;
    if (v[127:63] == {65{1'b0}} || v[127:63] == {65{1'b1}}) begin
      r = v[63:0];
    end else if (v[127]) begin
      r = {1'b1, 63'd0};
    end else begin
      r = {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  // Iteration limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Multiplier: one 32x32 partial product per step
  assign op_a   = pick(uw.mul_a, mx_q, my_q);
  assign op_b   = pick(uw.mul_b, mx_q, my_q);
  assign prod_d = op_a * op_b;

  // Accumulate the previous partial product at its weight
  always_comb begin
    case (uw.acc_sh)
      SH_0:    addend = {64'd0, prod_q};
      SH_32:   addend = {32'd0, prod_q, 32'd0};
      SH_33:   addend = {31'd0, prod_q, 33'd0};
      SH_64:   addend = {prod_q, 64'd0};
      default: addend = {64'd0, prod_q};
    endcase
    case (uw.acc_dst)
      D_XX:    acc_base = pxx_q;
      D_YY:    acc_base = pyy_q;
      D_XY:    acc_base = pxy_q;
      default: acc_base = '0;
    endcase
    if (uw.acc_load) begin
      acc_base = '0;
    end
  end
  assign acc_sum = acc_base + addend;

  // Escape test and limit test
  assign mag2            = pxx_q + pyy_q;
  assign stat_o.escaped  = (mag2 > ESC_LIMIT);
  assign stat_o.at_limit = (n_q == limit_q);

  // Signed 2xy from the magnitude product
  assign xy2 = neg_xy_q ? (128'd0 - {pxy_q[126:0], 1'b0}) : {pxy_q[126:0], 1'b0};

  // New z: drop fraction bits (floor), add c, clamp
  assign re_sh  = $signed(pxx_q) >>> FRACTION_BITS;
  assign im_sh  = $signed(pxy_q) >>> FRACTION_BITS;
  assign re_sum = re_sh + {{96{cr_q[31]}}, cr_q};
  assign im_sum = im_sh + {{96{ci_q[31]}}, ci_q};
  assign x_d    = sat64(re_sum);
  assign y_d    = sat64(im_sum);

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      cr_q <= c_real_i;
      ci_q <= c_imag_i;
      x_q  <= '0;
      y_q  <= '0;
      n_q  <= '0;
    end else if (ctrl_i.step) begin
      if (uw.mul_en) begin
        prod_q <= prod_d;
      end
      case (uw.acc_dst)
        D_XX:    pxx_q <= acc_sum;
        D_YY:    pyy_q <= acc_sum;
        D_XY:    pxy_q <= acc_sum;
        default: ;
      endcase
      case (uw.op)
        OP_MAG: begin
          mx_q     <= absval(x_q);
          my_q     <= absval(y_q);
          neg_xy_q <= x_q[63] ^ y_q[63];
        end
        OP_COMBINE: begin
          pxx_q <= pxx_q - pyy_q;
          pxy_q <= xy2;
        end
        OP_UPDATE: begin
          x_q <= x_d;
          y_q <= y_d;
          n_q <= n_q + LIMIT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      count_q   <= n_q;
      bounded_q <= !stat_o.escaped;
    end
  end

  assign iteration_count_o = count_q;
  assign stayed_bounded_o  = bounded_q;

endmodule

// ----- hw/rtl/mandelbrot_escape_time_core.sv -----
// Top level of the Mandelbrot escape-time core.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    c_real_i, c_imag_i (Q4.28)
//   out      output     out_valid_o / out_ready_i  iteration_count_o, stayed_bounded_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_data_i (iteration limit)
//
// One 32x32 multiplier is shared by all partial products; a 14-step control
// program runs one z update. One point is worked on at a time; the next is
// taken as soon as the last one is parked in the result register.
// Reset sets the iteration limit to 100 and leaves the core idle.
// A full result register stalls the core on its final check step.
module mandelbrot_escape_time_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mbe_pkg::LIMIT_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [31:0]          c_real_i,
  input  logic signed [31:0]          c_imag_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mbe_pkg::LIMIT_W-1:0] iteration_count_o,
  output logic                        stayed_bounded_o
);
  import mbe_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // Limit writes are always accepted
  assign cfg_ready_o = 1'b1;

  mbe_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  mbe_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .c_real_i          (c_real_i),
    .c_imag_i          (c_imag_i),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .iteration_count_o (iteration_count_o),
    .stayed_bounded_o  (stayed_bounded_o)
  );

endmodule
